// ===== src/switched_r6_ring_sum_assert.svh =====
// Assertion macros shared by the ring-sum block.
// Expects clk and rst_n in the scope of each use.
`ifndef SWITCHED_R6_RING_SUM_ASSERT_SVH
`define SWITCHED_R6_RING_SUM_ASSERT_SVH

// same-cycle implication
`define RS6_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RS6_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rs6_pkg.sv =====
// Shared constants, types and state codes of the switched r^-6 ring sum.
// No dependencies.
package rs6_pkg;

    localparam int COORD_FRAC_BITS = 12;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int R2_W    = 50;
    localparam int DIST_W  = 23;
    localparam int DSQ_W   = 46;
    localparam int NOISE_W = 17;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 3;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int X_W     = 30;
    localparam int M_W     = 31;
    localparam int M3_W    = 33;
    localparam int Q_W     = 28;
    localparam int TREM_W  = 47;
    localparam int QREM_W  = 34;
    localparam int E_W     = 6;
    localparam int STEP_W  = 5;
    localparam int WIDE_W  = SUM_W + Q_W;

    localparam int TDIV_STEPS = 30;
    localparam int QDIV_STEPS = 28;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [8:0] K_BASE = 9'(6 * COORD_FRAC_BITS - 2);

    localparam logic [SUM_W-1:0]   SUM_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX = '1;
    localparam logic [NOISE_W-1:0] S16_ONE = NOISE_W'(65536);
    localparam logic [MUL_W-1:0]   ONE30   = MUL_W'(32'h4000_0000);
    localparam logic [E_W-1:0]     E_TOP   = E_W'(R2_W - 1);

    // register indexes on the config port
    typedef enum logic [1:0] {
        REG_GUARD  = 2'd0,
        REG_ONSET  = 2'd1,
        REG_CUTOFF = 2'd2,
        REG_NOISE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DIST_W-1:0]  guard;
        logic [DIST_W-1:0]  onset;
        logic [DIST_W-1:0]  cutoff;
        logic [NOISE_W-1:0] noise;
    } cfg_t;

    // squared distance limits
    typedef struct packed {
        logic [DSQ_W-1:0] g2;
        logic [DSQ_W-1:0] on2;
        logic [DSQ_W-1:0] cut2;
    } dsq_t;

    typedef enum logic [1:0] {
        CLS_FULL,
        CLS_ZERO,
        CLS_TAPER
    } cls_t;

    typedef struct packed {
        logic [R2_W-1:0] r2;
        logic            pass;
        cls_t            cls;
        logic            last;
    } entry_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_TDIV,
        BK_TMUL1,
        BK_TMUL2,
        BK_EVAL,
        BK_NORM,
        BK_CUBE1,
        BK_CUBE2,
        BK_QDIV,
        BK_SCALE,
        BK_ACC
    } bk_state_t;

endpackage

// ===== src/rs6_if.sv =====
// Valid/ready channel interfaces for vertex beats in and ring results out.
// Depends on nothing.
interface rs6_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] atom_x;
    logic signed [23:0] atom_y;
    logic signed [23:0] atom_z;
    logic signed [23:0] vertex_x;
    logic signed [23:0] vertex_y;
    logic signed [23:0] vertex_z;
    logic               last_vertex;

    modport source (output valid, atom_x, atom_y, atom_z, vertex_x, vertex_y, vertex_z,
                    last_vertex, input ready);
    modport sink   (input valid, atom_x, atom_y, atom_z, vertex_x, vertex_y, vertex_z,
                    last_vertex, output ready);
endinterface

interface rs6_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] ring_sum;
    logic [2:0]  contact_count;

    modport source (output valid, ring_sum, contact_count, input ready);
    modport sink   (input valid, ring_sum, contact_count, output ready);
endinterface

// ===== src/rs6_queue.sv =====
// Short queue of classified vertices between front and back.
// Depends on rs6_pkg.
module rs6_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rs6_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_vld,
    output rs6_pkg::entry_t head
);
    import rs6_pkg::*;

    entry_t             mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_vld = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== src/rs6_front.sv =====
// Front end: takes vertex beats, forms r^2 in three stages and classifies it
// against the squared guard, onset and cutoff. Depends on rs6_pkg, rs6_if.
module rs6_front (
    input  logic            clk,
    input  logic            rst_n,
    rs6_in_if.sink          item_in,
    input  rs6_pkg::cfg_t   cfg,
    output rs6_pkg::dsq_t   dsq,
    output logic            push,
    output rs6_pkg::entry_t push_entry,
    input  logic            q_full
);
    import rs6_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    dsq_t              dsq_reg;
    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic              s1_last_reg, s2_last_reg;
    logic [R2_W-1:0]   s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    entry_t            s3_reg;
    entry_t            s3_next;
    logic              s3_push;
    logic              adv;

    // squared limits follow the config registers
    always_ff @(posedge clk)
    begin
        dsq_reg.g2   <= DSQ_W'(cfg.guard) * DSQ_W'(cfg.guard);
        dsq_reg.on2  <= DSQ_W'(cfg.onset) * DSQ_W'(cfg.onset);
        dsq_reg.cut2 <= DSQ_W'(cfg.cutoff) * DSQ_W'(cfg.cutoff);
    end
    assign dsq = dsq_reg;

    // stall the whole pipe only when a vertex must go to a full queue
    assign s3_push        = s3_vld_reg && (s3_reg.pass || s3_reg.last);
    assign adv            = !s3_push || !q_full;
    assign item_in.ready  = adv;
    assign push           = s3_push && adv;
    assign push_entry     = s3_reg;

    // sum of squares and classification
    always_comb
    begin
        s3_next.r2   = s2_sqx_reg + s2_sqy_reg + s2_sqz_reg;
        s3_next.pass = (s3_next.r2 >= R2_W'(dsq_reg.g2)) &&
                       (s3_next.r2 <= R2_W'(dsq_reg.cut2));
        s3_next.last = s2_last_reg;
        if (s3_next.r2 <= R2_W'(dsq_reg.on2))
        begin
            s3_next.cls = CLS_FULL;
        end
        else if (s3_next.r2 >= R2_W'(dsq_reg.cut2))
        begin
            s3_next.cls = CLS_ZERO;
        end
        else
        begin
            s3_next.cls = CLS_TAPER;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg   <= abs_diff(item_in.atom_x, item_in.vertex_x);
            s1_dy_reg   <= abs_diff(item_in.atom_y, item_in.vertex_y);
            s1_dz_reg   <= abs_diff(item_in.atom_z, item_in.vertex_z);
            s1_last_reg <= item_in.last_vertex;
            s2_sqx_reg  <= R2_W'(s1_dx_reg) * R2_W'(s1_dx_reg);
            s2_sqy_reg  <= R2_W'(s1_dy_reg) * R2_W'(s1_dy_reg);
            s2_sqz_reg  <= R2_W'(s1_dz_reg) * R2_W'(s1_dz_reg);
            s2_last_reg <= s1_last_reg;
            s3_reg      <= s3_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= item_in.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end
endmodule

// ===== src/rs6_back.sv =====
// Back end: taper, normalise, cube, divide and scale one vertex at a time on
// a shared multiplier, then accumulate and emit. Depends on rs6_pkg, rs6_if and the assertion header.
`include "switched_r6_ring_sum_assert.svh"

module rs6_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_vld,
    input  rs6_pkg::entry_t    head,
    output logic               pop,
    input  rs6_pkg::dsq_t      dsq,
    input  logic [16:0]        noise,
    rs6_out_if.source          result_out
);
    import rs6_pkg::*;

    bk_state_t           state_reg, state_next;
    entry_t              ent_reg, ent_next;
    logic [TREM_W-1:0]   rem_reg, rem_next;
    logic [X_W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MUL_W-1:0]    op_reg, op_next;
    logic [NOISE_W-1:0]  s16_reg, s16_next;
    logic [R2_W-1:0]     sh_reg, sh_next;
    logic [E_W-1:0]      e_reg, e_next;
    logic [M3_W-1:0]     m3_reg, m3_next;
    logic [SUM_W-1:0]    v_reg, v_next;
    logic                inc_reg, inc_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_vld_reg, out_vld_next;
    logic [SUM_W-1:0]    osum_reg, osum_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;

    logic [DSQ_W-1:0]    den;
    logic [TREM_W-1:0]   t_sh;
    logic                t_ge;
    logic [QREM_W-1:0]   d_sh;
    logic                d_ge;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic [M_W-1:0]      m_val;
    logic                keep;
    logic                emit_ok;
    logic [SUM_W-1:0]    scaled;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;

    assign den     = dsq.cut2 - dsq.on2;
    assign t_sh    = {rem_reg[TREM_W-2:0], 1'b0};
    assign t_ge    = (t_sh >= TREM_W'(den));
    assign d_sh    = {rem_reg[QREM_W-2:0], 1'b0};
    assign d_ge    = (d_sh >= QREM_W'(m3_reg));
    assign m_val   = sh_reg[R2_W-1 -: M_W];
    assign keep    = ent_reg.pass && (s16_reg >= noise);
    assign emit_ok = !out_vld_reg || result_out.ready;
    assign pop     = (state_reg == BK_IDLE) && head_vld;

    assign sum_add = {1'b0, sum_reg} + {1'b0, v_reg};
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            BK_TMUL1:
            begin
                mul_a = ONE30 - MUL_W'(quo_reg);
                mul_b = ONE30 - MUL_W'(quo_reg);
            end
            BK_TMUL2:
            begin
                mul_a = op_reg;
                mul_b = ONE30 + {1'b0, quo_reg, 1'b0};
            end
            BK_CUBE1:
            begin
                mul_a = MUL_W'(m_val);
                mul_b = MUL_W'(m_val);
            end
            BK_CUBE2:
            begin
                mul_a = op_reg;
                mul_b = MUL_W'(m_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // final scale by 2^k, k = K_BASE - 3e
    always_comb
    begin
        logic [7:0]          e3;
        logic signed [8:0]   k;
        logic [8:0]          nk;
        logic [WIDE_W-1:0]   wide;
        e3     = {2'b00, e_reg} + {1'b0, e_reg, 1'b0};
        k      = K_BASE - $signed({1'b0, e3});
        nk     = 9'(-k);
        wide   = WIDE_W'(quo_reg[Q_W-1:0]) << k[6:0];
        scaled = '0;
        if (k < 0)
        begin
            if (nk >= 9'(Q_W))
            begin
                scaled = '0;
            end
            else
            begin
                scaled = SUM_W'(quo_reg[Q_W-1:0] >> nk);
            end
        end
        else if (k >= 9'(SUM_W))
        begin
            scaled = SUM_MAX;
        end
        else if (wide[WIDE_W-1:SUM_W] != '0)
        begin
            scaled = SUM_MAX;
        end
        else
        begin
            scaled = wide[SUM_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_vld)
                begin
                    state_next = (head.pass && head.cls == CLS_TAPER) ? BK_TDIV : BK_EVAL;
                end
            end
            BK_TDIV:
            begin
                if (step_reg == STEP_W'(TDIV_STEPS - 1))
                begin
                    state_next = BK_TMUL1;
                end
            end
            BK_TMUL1: state_next = BK_TMUL2;
            BK_TMUL2: state_next = BK_EVAL;
            BK_EVAL:
            begin
                if (keep && s16_reg != '0 && ent_reg.r2 != '0)
                begin
                    state_next = BK_NORM;
                end
                else
                begin
                    state_next = BK_ACC;
                end
            end
            BK_NORM:
            begin
                if (sh_reg[R2_W-1])
                begin
                    state_next = BK_CUBE1;
                end
            end
            BK_CUBE1: state_next = BK_CUBE2;
            BK_CUBE2: state_next = BK_QDIV;
            BK_QDIV:
            begin
                if (step_reg == STEP_W'(QDIV_STEPS - 1))
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE: state_next = BK_ACC;
            BK_ACC:
            begin
                if (!ent_reg.last || emit_ok)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ent_next     = ent_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        op_next      = op_reg;
        s16_next     = s16_reg;
        sh_next      = sh_reg;
        e_next       = e_reg;
        m3_next      = m3_reg;
        v_next       = v_reg;
        inc_next     = inc_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        osum_next    = osum_reg;
        ocnt_next    = ocnt_reg;
        out_vld_next = out_vld_reg && !result_out.ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                ent_next  = head;
                rem_next  = TREM_W'(head.r2 - R2_W'(dsq.on2));
                quo_next  = '0;
                step_next = '0;
                s16_next  = (head.cls == CLS_FULL) ? S16_ONE : '0;
            end
            BK_TDIV:
            begin
                rem_next  = t_ge ? (t_sh - TREM_W'(den)) : t_sh;
                quo_next  = {quo_reg[X_W-2:0], t_ge};
                step_next = step_reg + 1'b1;
            end
            BK_TMUL1:
            begin
                op_next = prod[61:30];
            end
            BK_TMUL2:
            begin
                s16_next = prod[60:44];
            end
            BK_EVAL:
            begin
                inc_next = keep;
                sh_next  = ent_reg.r2;
                e_next   = E_TOP;
                if (keep && s16_reg != '0 && ent_reg.r2 == '0)
                begin
                    v_next = SUM_MAX;
                end
                else
                begin
                    v_next = '0;
                end
            end
            BK_NORM:
            begin
                if (!sh_reg[R2_W-1])
                begin
                    sh_next = {sh_reg[R2_W-2:0], 1'b0};
                    e_next  = e_reg - 1'b1;
                end
            end
            BK_CUBE1:
            begin
                op_next = prod[61:30];
            end
            BK_CUBE2:
            begin
                m3_next   = prod[62:30];
                rem_next  = TREM_W'(s16_reg) << 12;
                quo_next  = '0;
                step_next = '0;
            end
            BK_QDIV:
            begin
                rem_next  = TREM_W'(d_ge ? (d_sh - QREM_W'(m3_reg)) : d_sh);
                quo_next  = {quo_reg[X_W-2:0], d_ge};
                step_next = step_reg + 1'b1;
            end
            BK_SCALE:
            begin
                v_next = scaled;
            end
            BK_ACC:
            begin
                if (!ent_reg.last)
                begin
                    sum_next = sum_sat;
                    if (inc_reg && cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (emit_ok)
                begin
                    osum_next    = sum_sat;
                    ocnt_next    = (inc_reg && cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
                    out_vld_next = 1'b1;
                    sum_next     = '0;
                    cnt_next     = '0;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop || state_reg != BK_IDLE)
        begin
            ent_reg  <= ent_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_next;
            op_reg   <= op_next;
            s16_reg  <= s16_next;
            sh_reg   <= sh_next;
            e_reg    <= e_next;
            m3_reg   <= m3_next;
            v_reg    <= v_next;
            inc_reg  <= inc_next;
        end
        osum_reg <= osum_next;
        ocnt_reg <= ocnt_next;
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign result_out.valid         = out_vld_reg;
    assign result_out.ring_sum      = osum_reg;
    assign result_out.contact_count = ocnt_reg;

    `RS6_ASSERT_NOW(a_taper_cap, state_reg == BK_EVAL, s16_reg <= S16_ONE, "taper above one")
    `RS6_ASSERT_NOW(a_norm_lead, state_reg == BK_CUBE1, sh_reg[R2_W-1], "mantissa not normalised")
    `RS6_ASSERT_NOW(a_m3_floor, state_reg == BK_QDIV, m3_reg[M3_W-1:30] != '0, "cube below 2^30")
    `RS6_ASSERT_NEXT(a_ring_clear, state_reg == BK_ACC && ent_reg.last && emit_ok, sum_reg == '0 && cnt_reg == '0 && out_vld_reg, "ring not cleared on emit")
endmodule

// ===== src/switched_r6_ring_sum.sv =====
// Path: three front stages, the queue, then the back states; a vertex that fails
// its tests takes IDLE, EVAL, ACC; a kept one adds NORM, CUBE1/2, QDIV and SCALE, a tapered one TDIV, TMUL1/2.
// Throughput: one vertex per back pass; the 30-step taper divider, the
// normalising shift and the 28-step quotient divider set it.
// Reset (rst_n, async, active low) restores the default limits and clears
// the running sum, count, queue and output beat.
module switched_r6_ring_sum (
    input  logic        clk,
    input  logic        rst_n,
    rs6_in_if.sink      item_in,
    rs6_out_if.source   result_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data
);
    import rs6_pkg::*;

    cfg_t   cfg_reg;
    dsq_t   dsq;
    logic   push, q_full, pop, head_vld;
    entry_t push_entry, head;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.guard  <= DIST_W'(410);
            cfg_reg.onset  <= DIST_W'(17613);
            cfg_reg.cutoff <= DIST_W'(20480);
            cfg_reg.noise  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GUARD:  cfg_reg.guard  <= cfg_data;
                REG_ONSET:  cfg_reg.onset  <= cfg_data;
                REG_CUTOFF: cfg_reg.cutoff <= cfg_data;
                REG_NOISE:  cfg_reg.noise  <= cfg_data[NOISE_W-1:0];
                default:    cfg_reg.noise  <= cfg_reg.noise;
            endcase
        end
    end

    rs6_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .cfg        (cfg_reg),
        .dsq        (dsq),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    rs6_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_vld   (head_vld),
        .head       (head)
    );

    rs6_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_vld   (head_vld),
        .head       (head),
        .pop        (pop),
        .dsq        (dsq),
        .noise      (cfg_reg.noise),
        .result_out (result_out)
    );
endmodule
